@@ design/vsim_pkg.sv @@
// Package for the vsync interval trimmed-mean core.
// Holds shared constants, the sequencer state type and register indexes.
package vsim_pkg;

   localparam int DefaultWindowDepth = 512;
   localparam int DefaultIntervalBits = 24;
   localparam int CfgWidth = 24;
   localparam int CfgIndexBits = 1;
   localparam int TimeBits = 63;
   localparam int AvgBits = 24;
   localparam int HzBits = 20;
   localparam int CountBits = 10;
   localparam logic [CfgWidth-1:0] HalveThresholdReset = 24'd30000;
   localparam logic [CfgWidth-1:0] DefaultIntervalReset = 24'd16667;
   localparam logic [HzBits-1:0] HzMax = 20'd1000000;
   localparam logic [AvgBits-1:0] AvgMax = {AvgBits{1'b1}};

   localparam logic [CfgIndexBits-1:0] RegHalveThreshold = 1'b0;
   localparam logic [CfgIndexBits-1:0] RegDefaultInterval = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVICT_RD,
      ST_FIND,
      ST_REMOVE,
      ST_INSERT_FIND,
      ST_INSERT_SHIFT,
      ST_INSERT_PUT,
      ST_SUM,
      ST_DIV_AVG,
      ST_DIV_HZ,
      ST_RESULT
   } seq_state_type;

endpackage

@@ design/vsync_interval_trimmed_mean_core.sv @@
// Vsync interval trimmed-mean core: top level with window memories and sequencer.
// Depends on vsim_pkg and vsim_divider.
// Work per word: the sequencer walks the window entries one by one, then runs the divider bit by bit.
// Throughput: one word at a time; req_ready is low while a word is in work or its result waits.
// Reset: synchronous; clears the held timestamp, count and pointers, no memory sweep.
module vsync_interval_trimmed_mean_core #(
   parameter int WINDOW_DEPTH  = vsim_pkg::DefaultWindowDepth,
   parameter int INTERVAL_BITS = vsim_pkg::DefaultIntervalBits
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [vsim_pkg::TimeBits-1:0]    req_vsync_time,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [vsim_pkg::AvgBits-1:0]     rsp_interval_avg,
   output logic [vsim_pkg::HzBits-1:0]      rsp_refresh_hz,
   output logic [vsim_pkg::CountBits-1:0]   rsp_sample_count,
   output logic                             rsp_sample_added,
   input  logic                             csr_write,
   input  logic [vsim_pkg::CfgIndexBits-1:0] csr_index,
   input  logic [vsim_pkg::CfgWidth-1:0]    csr_data
);
   import vsim_pkg::*;

   localparam int AddrBits = $clog2(WINDOW_DEPTH);
   localparam int CntBits  = $clog2(WINDOW_DEPTH + 1);
   localparam int SumBits  = INTERVAL_BITS + CntBits;
   localparam int NumBits  = SumBits + HzBits;
   localparam logic [INTERVAL_BITS-1:0] IntervalMax = {INTERVAL_BITS{1'b1}};

   seq_state_type state_ff, state_in;

   logic [CfgWidth-1:0] thresh_ff, defint_ff;
   logic [TimeBits-1:0] prev_ff, prev_in;
   logic [CntBits-1:0]  count_ff, count_in;
   logic [AddrBits-1:0] oldest_ff, oldest_in;
   logic [INTERVAL_BITS-1:0] sample_ff, sample_in;
   logic [INTERVAL_BITS-1:0] victim_ff, victim_in;
   logic                added_ff, added_in;
   logic [CntBits-1:0]  idx_ff, idx_in;    // walking index
   logic [CntBits-1:0]  lim_ff, lim_in;    // entries held in sorted order
   logic [SumBits-1:0]  sum_ff, sum_in;
   logic [CntBits-1:0]  nterm_ff, nterm_in;
   logic                rd_wait_ff, rd_wait_in;
   logic [AvgBits-1:0]  avg_ff, avg_in;
   logic [HzBits-1:0]   hz_ff, hz_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Window memories.
   logic [INTERVAL_BITS-1:0] arr_mem [WINDOW_DEPTH];
   logic [INTERVAL_BITS-1:0] srt_mem [WINDOW_DEPTH];
   logic                     arr_we, srt_we;
   logic [AddrBits-1:0]      arr_waddr, arr_raddr, srt_waddr, srt_raddr;
   logic [INTERVAL_BITS-1:0] arr_wdata, srt_wdata, arr_rdata_ff, srt_rdata_ff;

   always_ff @(posedge clock) begin
      if (arr_we) arr_mem[arr_waddr] <= arr_wdata;
      if (srt_we) srt_mem[srt_waddr] <= srt_wdata;
      arr_rdata_ff <= arr_mem[arr_raddr];
      srt_rdata_ff <= srt_mem[srt_raddr];
   end

   // Divider shared by the mean and the rate.
   logic                div_start, div_done;
   logic [NumBits-1:0]  div_num, div_q;
   logic [SumBits-1:0]  div_den;

   vsim_divider #(.NUM_BITS(NumBits), .DEN_BITS(SumBits)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numerator(div_num), .denominator(div_den),
      .done(div_done), .quotient(div_q)
   );

   // Rate numerator: one million times the number of trimmed entries.
   logic [HzBits+CntBits-1:0] hz_num;
   assign hz_num = HzMax * nterm_ff;

   // New interval from the timestamp difference.
   logic [TimeBits-1:0] diff_raw, diff_half;
   always_comb begin
      diff_raw  = req_vsync_time - prev_ff;
      diff_half = diff_raw;
      if (req_vsync_time < prev_ff) diff_half = '0;
      else if (diff_raw > TimeBits'(thresh_ff)) diff_half = diff_raw >> 1;
      if (diff_half > TimeBits'(IntervalMax)) sample_in = IntervalMax;
      else sample_in = diff_half[INTERVAL_BITS-1:0];
   end

   logic [AddrBits-1:0] idx_a;
   logic [AddrBits-1:0] start_a;
   logic [CntBits:0]    wr_slot_full;
   logic [AddrBits-1:0] wr_slot;
   assign idx_a   = idx_ff[AddrBits-1:0];
   assign start_a = AddrBits'(count_ff >> 2);
   // Arrival slot after the newest entry, wrapped at the window depth.
   assign wr_slot_full = (CntBits+1)'(oldest_ff) + (CntBits+1)'(count_ff);
   assign wr_slot = (wr_slot_full >= (CntBits+1)'(WINDOW_DEPTH)) ?
                    AddrBits'(wr_slot_full - (CntBits+1)'(WINDOW_DEPTH)) :
                    AddrBits'(wr_slot_full);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      prev_in = prev_ff; count_in = count_ff; oldest_in = oldest_ff;
      victim_in = victim_ff; added_in = added_ff; idx_in = idx_ff; lim_in = lim_ff;
      sum_in = sum_ff; nterm_in = nterm_ff; rd_wait_in = 1'b0;
      avg_in = avg_ff; hz_in = hz_ff; rsp_valid_in = rsp_valid_ff;
      arr_we = 1'b0; arr_waddr = '0; arr_wdata = sample_ff; arr_raddr = oldest_ff;
      srt_we = 1'b0; srt_waddr = idx_a; srt_wdata = srt_rdata_ff; srt_raddr = idx_a;
      div_start = 1'b0; div_num = '0; div_den = sum_ff;
      req_ready = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !rsp_valid_ff;
            if (req_valid && !rsp_valid_ff) begin
               prev_in  = req_vsync_time;
               added_in = (prev_ff != '0);
               idx_in   = '0;
               if (prev_ff == '0) begin
                  idx_in = '0; sum_in = '0; rd_wait_in = 1'b1;
                  nterm_in = count_ff >> 1;
                  state_in = ST_SUM;
               end else if (count_ff == CntBits'(WINDOW_DEPTH)) begin
                  state_in = ST_EVICT_RD;
               end else begin
                  arr_we = 1'b1;
                  arr_wdata = sample_in;
                  arr_waddr = wr_slot;
                  lim_in = count_ff;
                  rd_wait_in = 1'b1;
                  state_in = ST_INSERT_FIND;
               end
            end
         end
         ST_EVICT_RD: begin
            // Arrival read of the oldest slot is used once rd_wait is set.
            arr_raddr = oldest_ff;
            if (!rd_wait_ff) begin
               rd_wait_in = 1'b1;
            end else begin
               victim_in = arr_rdata_ff;
               arr_we = 1'b1; arr_waddr = oldest_ff; arr_wdata = sample_ff;
               oldest_in = (oldest_ff == AddrBits'(WINDOW_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
               idx_in = '0; rd_wait_in = 1'b1;
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            // Scan for the victim; read of idx is valid when rd_wait is clear.
            srt_raddr = idx_a;
            if (!rd_wait_ff) begin
               if (srt_rdata_ff == victim_ff || idx_ff == CntBits'(WINDOW_DEPTH - 1)) begin
                  state_in = ST_REMOVE; rd_wait_in = 1'b1;
                  srt_raddr = AddrBits'(idx_ff + 1'b1);
               end else begin
                  idx_in = idx_ff + 1'b1; rd_wait_in = 1'b1;
                  srt_raddr = AddrBits'(idx_ff + 1'b1);
               end
            end
         end
         ST_REMOVE: begin
            // Shift entries above the victim down by one.
            srt_raddr = AddrBits'(idx_ff + 1'b1);
            if (idx_ff + 1'b1 >= CntBits'(WINDOW_DEPTH)) begin
               lim_in = CntBits'(WINDOW_DEPTH - 1); idx_in = '0; rd_wait_in = 1'b1;
               state_in = ST_INSERT_FIND;
            end else if (!rd_wait_ff) begin
               srt_we = 1'b1; srt_waddr = idx_a; srt_wdata = srt_rdata_ff;
               idx_in = idx_ff + 1'b1; rd_wait_in = 1'b1;
               srt_raddr = AddrBits'(idx_ff + 2'd2);
            end
         end
         ST_INSERT_FIND: begin
            // First position whose entry exceeds the new sample.
            srt_raddr = idx_a;
            if (idx_ff >= lim_ff) begin
               state_in = ST_INSERT_PUT;
            end else if (!rd_wait_ff) begin
               if (srt_rdata_ff > sample_ff) begin
                  idx_in = lim_ff; rd_wait_in = 1'b1;
                  victim_in = srt_rdata_ff;   // entry at the insertion point; its index is kept in nterm
                  nterm_in = idx_ff;
                  state_in = ST_INSERT_SHIFT;
                  srt_raddr = AddrBits'(lim_ff - 1'b1);
               end else begin
                  idx_in = idx_ff + 1'b1; rd_wait_in = 1'b1;
                  srt_raddr = AddrBits'(idx_ff + 1'b1);
               end
            end
         end
         ST_INSERT_SHIFT: begin
            // Move entries from the top down to the insertion index.
            srt_raddr = AddrBits'(idx_ff - 1'b1);
            if (idx_ff == nterm_ff) begin
               state_in = ST_INSERT_PUT;
            end else if (!rd_wait_ff) begin
               srt_we = 1'b1; srt_waddr = idx_a; srt_wdata = srt_rdata_ff;
               idx_in = idx_ff - 1'b1; rd_wait_in = 1'b1;
               srt_raddr = AddrBits'(idx_ff - 2'd2);
            end
         end
         ST_INSERT_PUT: begin
            srt_we = 1'b1; srt_waddr = idx_a; srt_wdata = sample_ff;
            if (count_ff != CntBits'(WINDOW_DEPTH)) count_in = count_ff + 1'b1;
            state_in = ST_SUM;
            idx_in = '0; sum_in = '0; rd_wait_in = 1'b1;
         end
         ST_SUM: begin
            // Accumulate the middle half of the sorted entries.
            srt_raddr = AddrBits'(CntBits'(start_a) + idx_ff);
            nterm_in = count_ff >> 1;
            if (idx_ff >= (count_ff >> 1)) begin
               if ((count_ff >> 1) == '0) begin
                  avg_in = defint_ff;
                  div_start = (defint_ff != '0);
                  div_num = NumBits'(HzMax);
                  div_den = SumBits'(defint_ff);
                  if (defint_ff == '0) begin
                     hz_in = HzMax; state_in = ST_RESULT;
                  end else state_in = ST_DIV_HZ;
               end else if (sum_ff == '0) begin
                  avg_in = '0; hz_in = HzMax; state_in = ST_RESULT;
               end else begin
                  div_start = 1'b1;
                  div_num = NumBits'(sum_ff);
                  div_den = SumBits'(count_ff >> 1);
                  state_in = ST_DIV_AVG;
               end
            end else if (!rd_wait_ff) begin
               sum_in = sum_ff + SumBits'(srt_rdata_ff);
               idx_in = idx_ff + 1'b1; rd_wait_in = 1'b1;
               srt_raddr = AddrBits'(CntBits'(start_a) + idx_ff + 1'b1);
            end
         end
         ST_DIV_AVG: begin
            div_den = SumBits'(nterm_ff);
            if (div_done) begin
               avg_in = (div_q > NumBits'(AvgMax)) ? AvgMax : div_q[AvgBits-1:0];
               div_start = 1'b1;
               div_num = NumBits'(hz_num);
               div_den = sum_ff;
               state_in = ST_DIV_HZ;
            end
         end
         ST_DIV_HZ: begin
            if (div_done) begin
               hz_in = (div_q > NumBits'(HzMax)) ? HzMax : div_q[HzBits-1:0];
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thresh_ff <= HalveThresholdReset;
         defint_ff <= DefaultIntervalReset;
         prev_ff <= '0;
         count_ff <= '0;
         oldest_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_wait_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         prev_ff <= prev_in;
         count_ff <= count_in;
         oldest_ff <= oldest_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_wait_ff <= rd_wait_in;
         idx_ff <= idx_in;
         if (csr_write) begin
            unique case (csr_index)
               RegHalveThreshold:  thresh_ff <= csr_data;
               RegDefaultInterval: defint_ff <= csr_data;
               default: ;
            endcase
         end
      end
      sample_ff <= (state_ff == ST_IDLE) ? sample_in : sample_ff;
      victim_ff <= victim_in;
      added_ff <= added_in;
      lim_ff <= lim_in;
      sum_ff <= sum_in;
      nterm_ff <= nterm_in;
      avg_ff <= avg_in;
      hz_ff <= hz_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interval_avg = avg_ff;
   assign rsp_refresh_hz   = hz_ff;
   assign rsp_sample_count = CountBits'(count_ff);
   assign rsp_sample_added = added_ff;
endmodule

@@ design/vsim_divider.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters; used for the mean and the rate.
module vsim_divider #(
   parameter int NUM_BITS = 56,
   parameter int DEN_BITS = 46
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numerator,
   input  logic [DEN_BITS-1:0] denominator,
   output logic                done,
   output logic [NUM_BITS-1:0] quotient
);
   localparam int CntBits = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS+1:0] trial;

   // One shift and subtract step per cycle.
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         quot_in = numerator;
         rem_in  = '0;
         den_in  = denominator;
         cnt_in  = CntBits'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quot_ff[NUM_BITS-1]} - {2'b00, den_ff};
         if (!trial[DEN_BITS+1]) begin
            rem_in  = trial[DEN_BITS:0];
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in  = {rem_ff[DEN_BITS-1:0], quot_ff[NUM_BITS-1]};
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule
